### rtl/life_rle_pattern_decoder_unit_macros.svh
// Assertion macros used by the checker of the run-length decoder.
`ifndef LIFE_RLE_PATTERN_DECODER_UNIT_MACROS_SVH
`define LIFE_RLE_PATTERN_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define LRLE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define LRLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also watches the reset itself.
`define LRLE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lrle_pkg.sv
package lrle_pkg;

  localparam int RUN_W   = 16;
  localparam int PAD_W   = 13;
  localparam int BLANK_W = 16;
  localparam int POS_W   = 16;
  localparam int WIDTH_W = 13;
  localparam int KIND_W  = 2;

  localparam logic [WIDTH_W-1:0] WIDTH_MAX       = 13'd4096;
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd64;
  localparam logic [POS_W-1:0]   POS_MAX         = 16'hFFFF;

  localparam logic [KIND_W-1:0] KIND_RUN     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ROW_END = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PAT_END = 2'd2;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_ROW_END = 8'h24;
  localparam logic [7:0] CH_PAT_END = 8'h21;
  localparam logic [7:0] CH_DEAD    = 8'h62;

  typedef struct packed {
    logic [KIND_W-1:0]  item_kind;
    logic               cell_alive;
    logic [RUN_W-1:0]   run_length;
    logic [PAD_W-1:0]   pad_length;
    logic [BLANK_W-1:0] blank_rows;
    logic               overflow;
  } result_t;

endpackage

### rtl/lrle_char_if.sv
interface lrle_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

### rtl/lrle_result_if.sv
interface lrle_result_if;
  logic                             valid;
  logic                             ready;
  logic [lrle_pkg::KIND_W-1:0]      item_kind;
  logic                             cell_alive;
  logic [lrle_pkg::RUN_W-1:0]       run_length;
  logic [lrle_pkg::PAD_W-1:0]       pad_length;
  logic [lrle_pkg::BLANK_W-1:0]     blank_rows;
  logic                             overflow;

  modport source (output valid, output item_kind, output cell_alive, output run_length,
                  output pad_length, output blank_rows, output overflow, input ready);
  modport sink (input valid, input item_kind, input cell_alive, input run_length,
                input pad_length, input blank_rows, input overflow, output ready);
endinterface

### rtl/lrle_skid.sv
// Output register with one skid entry, so the producer may push in the
// cycle in which the consumer stalls.
module lrle_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  lrle_pkg::result_t push_data,
  output logic              push_ready,
  output logic              pop_valid,
  input  logic              pop_ready,
  output lrle_pkg::result_t pop_data
);

  logic              out_valid;
  lrle_pkg::result_t out_data;
  logic              skid_valid;
  lrle_pkg::result_t skid_data;
  logic              pop_fire;

  assign push_ready = !skid_valid;
  assign pop_valid  = out_valid;
  assign pop_data   = out_data;
  assign pop_fire   = out_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        // No push is taken while the skid entry is full.
        if (pop_fire) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (push_valid) begin
        if (!out_valid || pop_fire) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop_fire) begin
        out_data <= skid_data;
      end
    end else if (push_valid) begin
      if (!out_valid || pop_fire) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

### rtl/life_rle_pattern_decoder_unit.sv
// Run-length pattern decoder for cellular-automaton text.
// The char_in channel takes one byte of pattern text per item. Whitespace is
// skipped, digits build a run count, 'b' and every other cell character emit
// a cell run, '$' emits a row end with its dead padding and the number of
// extra blank rows, and '!' emits a pattern end and returns to the start.
// The result_out channel carries at most one item for each accepted byte.
// The row width is set through cfg_we / cfg_wdata; the user must write it only while the block is idle (not enforced).
// A result is registered in the output register, or in the skid entry while the receiver stalls.
// Throughput: one byte per cycle while the skid entry is empty; the count and row position are
// updated by a single short step in the cycle of acceptance, so nothing in
// the block loops.
// When the receiver stalls, the result held in the output register waits and
// one more result can enter a skid entry; char_in.ready falls only while
// that skid entry is full.
// Reset (rst, synchronous, active high) clears the count, the row position
// and both output entries, and sets the row width to 64.
module life_rle_pattern_decoder_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lrle_pkg::WIDTH_W-1:0]  cfg_wdata,
  lrle_char_if.sink                     char_in,
  lrle_result_if.source                 result_out
);

  // The sum of position and count must hold either operand plus a carry.
  localparam int SUM_W = ((COUNT_BITS > lrle_pkg::POS_W) ? COUNT_BITS : lrle_pkg::POS_W) + 1;
  localparam int MUL_W = COUNT_BITS + 4;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Architectural state.
  logic [COUNT_BITS-1:0]         pending_count;
  logic                          count_present;
  logic [lrle_pkg::POS_W-1:0]    row_position;
  logic [lrle_pkg::WIDTH_W-1:0]  row_width;

  logic [COUNT_BITS-1:0]         pending_count_next;
  logic                          count_present_next;
  logic [lrle_pkg::POS_W-1:0]    row_position_next;

  logic accept;
  logic is_space;
  logic is_digit;
  logic is_row_end;
  logic is_pat_end;

  logic [COUNT_BITS-1:0]         run_count;
  logic                          run_zero;
  logic [MUL_W-1:0]              times_ten;
  logic [COUNT_BITS-1:0]         digit_count;
  logic [SUM_W-1:0]              pos_sum;
  logic [lrle_pkg::POS_W-1:0]    pos_advanced;
  logic [lrle_pkg::WIDTH_W-1:0]  width_eff;
  logic                          pad_ovf;
  logic [lrle_pkg::PAD_W-1:0]    pad_cells;

  logic              res_valid;
  lrle_pkg::result_t res;
  logic              buf_ready;
  logic              buf_valid;
  lrle_pkg::result_t buf_data;

  assign accept = char_in.valid && char_in.ready;

  // Character classes.
  assign is_space   = (char_in.char_code == lrle_pkg::CH_SPACE) ||
                      (char_in.char_code == lrle_pkg::CH_TAB) ||
                      (char_in.char_code == lrle_pkg::CH_NEWLINE);
  assign is_digit   = (char_in.char_code >= lrle_pkg::CH_ZERO) &&
                      (char_in.char_code <= lrle_pkg::CH_NINE);
  assign is_row_end = (char_in.char_code == lrle_pkg::CH_ROW_END);
  assign is_pat_end = (char_in.char_code == lrle_pkg::CH_PAT_END);

  // An empty count stands for a run of one.
  assign run_count = count_present ? pending_count : COUNT_BITS'(1);
  assign run_zero  = (run_count == '0);

  // Next decimal digit: count * 10 as two shifts and an add, then saturate.
  assign times_ten = (MUL_W'(pending_count) << 3) + (MUL_W'(pending_count) << 1) +
                     MUL_W'(char_in.char_code - lrle_pkg::CH_ZERO);
  assign digit_count = (times_ten > MUL_W'(COUNT_MAX)) ? COUNT_MAX
                                                       : times_ten[COUNT_BITS-1:0];

  // Row position after a cell run, saturating at its register width.
  assign pos_sum      = SUM_W'(row_position) + SUM_W'(run_count);
  assign pos_advanced = (pos_sum > SUM_W'(lrle_pkg::POS_MAX)) ? lrle_pkg::POS_MAX
                                                              : pos_sum[lrle_pkg::POS_W-1:0];

  // Padding to the row width; a position past the width clamps to zero.
  // When no overflow occurs the position is at most 4096 and fits the pad.
  assign width_eff = (row_width > lrle_pkg::WIDTH_MAX) ? lrle_pkg::WIDTH_MAX : row_width;
  assign pad_ovf   = (row_position > lrle_pkg::POS_W'(width_eff));
  assign pad_cells = pad_ovf ? '0 : (width_eff - row_position[lrle_pkg::PAD_W-1:0]);

  always_comb begin
    pending_count_next = pending_count;
    count_present_next = count_present;
    row_position_next  = row_position;
    res_valid          = 1'b0;
    res                = '0;
    priority if (is_space) begin
      // Whitespace leaves everything as it is.
    end else if (is_digit) begin
      pending_count_next = digit_count;
      count_present_next = 1'b1;
    end else if (is_row_end) begin
      pending_count_next = '0;
      count_present_next = 1'b0;
      // An explicit zero count does not end the row.
      if (!run_zero) begin
        row_position_next = '0;
        res_valid         = 1'b1;
        res.item_kind     = lrle_pkg::KIND_ROW_END;
        res.pad_length    = pad_cells;
        res.blank_rows    = lrle_pkg::BLANK_W'(run_count - COUNT_BITS'(1));
        res.overflow      = pad_ovf;
      end
    end else if (is_pat_end) begin
      pending_count_next = '0;
      count_present_next = 1'b0;
      row_position_next  = '0;
      res_valid          = 1'b1;
      res.item_kind      = lrle_pkg::KIND_PAT_END;
      res.pad_length     = pad_cells;
      res.overflow       = pad_ovf;
    end else begin
      pending_count_next = '0;
      count_present_next = 1'b0;
      row_position_next  = pos_advanced;
      res_valid          = 1'b1;
      res.item_kind      = lrle_pkg::KIND_RUN;
      res.cell_alive     = (char_in.char_code != lrle_pkg::CH_DEAD);
      res.run_length     = lrle_pkg::RUN_W'(run_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= '0;
      count_present <= 1'b0;
      row_position  <= '0;
      row_width     <= lrle_pkg::ROW_WIDTH_RESET;
    end else begin
      if (accept) begin
        pending_count <= pending_count_next;
        count_present <= count_present_next;
        row_position  <= row_position_next;
      end
      if (cfg_we) begin
        row_width <= cfg_wdata;
      end
    end
  end

  lrle_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push_valid (accept && res_valid),
    .push_data  (res),
    .push_ready (buf_ready),
    .pop_valid  (buf_valid),
    .pop_ready  (result_out.ready),
    .pop_data   (buf_data)
  );

  assign char_in.ready         = buf_ready;
  assign result_out.valid      = buf_valid;
  assign result_out.item_kind  = buf_data.item_kind;
  assign result_out.cell_alive = buf_data.cell_alive;
  assign result_out.run_length = buf_data.run_length;
  assign result_out.pad_length = buf_data.pad_length;
  assign result_out.blank_rows = buf_data.blank_rows;
  assign result_out.overflow   = buf_data.overflow;

endmodule

### rtl/lrle_checker.sv
`include "life_rle_pattern_decoder_unit_macros.svh"

module lrle_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [lrle_pkg::KIND_W-1:0]    item_kind,
  input logic                           cell_alive,
  input logic [lrle_pkg::RUN_W-1:0]     run_length,
  input logic [lrle_pkg::PAD_W-1:0]     pad_length,
  input logic [lrle_pkg::BLANK_W-1:0]   blank_rows,
  input logic                           overflow
);

  // A stalled result keeps its kind, run length, padding and blank rows.
  `LRLE_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(item_kind) && $stable(run_length) && $stable(pad_length) && $stable(blank_rows), "stalled result changed")

  // Runs carry no padding, blank rows or overflow.
  `LRLE_ASSERT_NOW(a_run_fields, clk, rst, out_valid && item_kind == lrle_pkg::KIND_RUN, pad_length == '0 && blank_rows == '0 && !overflow, "run carries row-end fields")

  // Row and pattern ends carry no run; an overflowed row has no padding.
  `LRLE_ASSERT_NOW(a_end_fields, clk, rst, out_valid && item_kind != lrle_pkg::KIND_RUN, !cell_alive && run_length == '0 && pad_length <= lrle_pkg::WIDTH_MAX && (!overflow || pad_length == '0), "end item fields inconsistent")

  // Reset empties the output.
  `LRLE_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "result valid after reset")

endmodule

bind life_rle_pattern_decoder_unit lrle_checker u_lrle_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result_out.valid),
  .out_ready  (result_out.ready),
  .item_kind  (result_out.item_kind),
  .cell_alive (result_out.cell_alive),
  .run_length (result_out.run_length),
  .pad_length (result_out.pad_length),
  .blank_rows (result_out.blank_rows),
  .overflow   (result_out.overflow)
);

### bench/life_rle_pattern_decoder_unit_tb.sv
module life_rle_pattern_decoder_unit_tb;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned COUNT_MAX     = 65535;
  localparam int unsigned RANDOM_ITEMS  = 1050;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [lrle_pkg::WIDTH_W-1:0] cfg_wdata;

  lrle_char_if char_bus();
  lrle_result_if result_bus();

  life_rle_pattern_decoder_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .char_in(char_bus),
    .result_out(result_bus)
  );

  // Shadow copy of the decoder state, updated as each item is accepted.
  logic [lrle_pkg::WIDTH_W-1:0] shadow_width = lrle_pkg::ROW_WIDTH_RESET;
  int unsigned shadow_count = 0;
  bit shadow_has_count = 1'b0;
  int unsigned shadow_pos = 0;

  // Results the decoder still owes us, oldest first.
  lrle_pkg::result_t decoded_items[$];

  int unsigned mismatches = 0;
  int unsigned chars_sent = 0;
  bit src_gaps = 1'b1;
  bit sink_stalls = 1'b1;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is abandoned if it goes on far longer than any correct run could.
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic bit is_blank(input logic [7:0] ch);
    return ch == lrle_pkg::CH_SPACE || ch == lrle_pkg::CH_TAB ||
           ch == lrle_pkg::CH_NEWLINE;
  endfunction

  // An empty count stands for a single cell; taking it clears it.
  function automatic int unsigned take_count();
    int unsigned n;
    n = shadow_has_count ? shadow_count : 1;
    shadow_count = 0;
    shadow_has_count = 1'b0;
    return n;
  endfunction

  // Dead cells that finish the row. Widths above the maximum are clamped, and
  // a position past the width clamps the pad to zero and flags an overflow.
  function automatic int unsigned row_pad(output bit ovf);
    int unsigned w;
    w = (shadow_width > lrle_pkg::WIDTH_MAX) ? int'(lrle_pkg::WIDTH_MAX)
                                             : int'(shadow_width);
    ovf = shadow_pos > w;
    return ovf ? 0 : w - shadow_pos;
  endfunction

  // Advances the shadow state by one character and reports whether the
  // decoder owes a result for it.
  function automatic bit decode_char(input logic [7:0] ch, output lrle_pkg::result_t res);
    longint unsigned acc;
    int unsigned n;
    int unsigned pad;
    bit ovf;
    res = '0;
    if (is_blank(ch)) return 1'b0;
    if (ch >= lrle_pkg::CH_ZERO && ch <= lrle_pkg::CH_NINE) begin
      acc = 64'(shadow_count) * 10 + 64'(ch - lrle_pkg::CH_ZERO);
      if (acc > COUNT_MAX) acc = COUNT_MAX;
      shadow_count = int'(acc);
      shadow_has_count = 1'b1;
      return 1'b0;
    end
    if (ch == lrle_pkg::CH_ROW_END) begin
      n = take_count();
      // An explicit zero count leaves the row open.
      if (n == 0) return 1'b0;
      pad = row_pad(ovf);
      shadow_pos = 0;
      res.item_kind = lrle_pkg::KIND_ROW_END;
      res.pad_length = lrle_pkg::PAD_W'(pad);
      res.blank_rows = lrle_pkg::BLANK_W'(n - 1);
      res.overflow = ovf;
      return 1'b1;
    end
    if (ch == lrle_pkg::CH_PAT_END) begin
      pad = row_pad(ovf);
      shadow_count = 0;
      shadow_has_count = 1'b0;
      shadow_pos = 0;
      res.item_kind = lrle_pkg::KIND_PAT_END;
      res.pad_length = lrle_pkg::PAD_W'(pad);
      res.overflow = ovf;
      return 1'b1;
    end
    // Everything else is a cell character; only 'b' gives dead cells.
    n = take_count();
    shadow_pos = (shadow_pos + n > int'(lrle_pkg::POS_MAX)) ? int'(lrle_pkg::POS_MAX)
                                                            : shadow_pos + n;
    res.item_kind = lrle_pkg::KIND_RUN;
    res.cell_alive = ch != lrle_pkg::CH_DEAD;
    res.run_length = lrle_pkg::RUN_W'(n);
    return 1'b1;
  endfunction

  // Presents one character, waits for it to be taken, and records what the
  // decoder should answer. Valid stays high between back-to-back items.
  task automatic send_char(input logic [7:0] ch);
    lrle_pkg::result_t res;
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      char_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    char_bus.valid <= 1'b1;
    char_bus.char_code <= ch;
    do @(posedge clk); while (!char_bus.ready);
    chars_sent++;
    if (decode_char(ch, res)) decoded_items.insert(decoded_items.size(), res);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Stops the sender and waits until every owed result has come back, plus a
  // settle period for characters that produce nothing.
  task automatic wait_idle();
    char_bus.valid <= 1'b0;
    while (decoded_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_row_width(input logic [lrle_pkg::WIDTH_W-1:0] w);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_width = w;
  endtask

  // Receiver: ready drops for random bursts while stalls are enabled.
  initial begin
    forever begin
      if (sink_stalls && $urandom_range(0, 5) == 0) begin
        result_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Every result taken off the output channel is matched against the oldest
  // owed result, one field at a time.
  always @(posedge clk) begin
    lrle_pkg::result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (decoded_items.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d run %0d pad %0d",
                 $time, result_bus.item_kind, result_bus.run_length,
                 result_bus.pad_length);
        mismatches++;
      end else begin
        want = decoded_items.pop_front();
        check_field("item_kind", int'(want.item_kind), int'(result_bus.item_kind));
        check_field("cell_alive", int'(want.cell_alive), int'(result_bus.cell_alive));
        check_field("run_length", int'(want.run_length), int'(result_bus.run_length));
        check_field("pad_length", int'(want.pad_length), int'(result_bus.pad_length));
        check_field("blank_rows", int'(want.blank_rows), int'(result_bus.blank_rows));
        check_field("overflow", int'(want.overflow), int'(result_bus.overflow));
      end
    end
  end

  // Every kind of character once at the reset width of 64: dead and live
  // runs, skipped whitespace, a row end, a zero count on a row end (no item
  // out) and on a cell (an empty run), control and high bytes as live cells,
  // a saturated count on a row end and a final row that overruns the width.
  task automatic test_basic_chars();
    send_text("bo3o \t\n$0$0o");
    send_char(8'h00);
    send_char(8'hFF);
    send_text("999999$70b!");
  endtask

  // The same text under narrow, empty, maximum and out-of-range widths.
  task automatic test_row_widths();
    logic [lrle_pkg::WIDTH_W-1:0] widths[7] = '{13'd1, 13'd0, 13'h1FFF, 13'd4096, 13'd4097,
                                               13'd4095, lrle_pkg::ROW_WIDTH_RESET};
    foreach (widths[i]) begin
      set_row_width(widths[i]);
      send_text("$o$2o$4095b$4096o!4097b$10b3$o!");
    end
  endtask

  // Row position saturation shows up as an overflow where a wrapped position
  // would give a full pad; oversized counts saturate in runs and blank rows.
  task automatic test_saturation();
    set_row_width(lrle_pkg::WIDTH_MAX);
    send_text("65535o1o$65536b!123456789$0000o!");
  endtask

  // A pattern end drops a pending count, and a zero count on a row end keeps
  // the position of the open row.
  task automatic test_count_clearing();
    send_text("3!o$5o0$$5o!$12");
    send_text("!b!");
  endtask

  task automatic send_random_count();
    int unsigned pick;
    int unsigned n;
    string digits;
    pick = $urandom_range(0, 99);
    if (pick < 40) return;
    if (pick < 80) n = $urandom_range(1, 12);
    else if (pick < 88) n = $urandom_range(13, 300);
    else if (pick < 93) n = 0;
    else if (pick < 97) n = $urandom_range(1, COUNT_MAX);
    else n = $urandom_range(COUNT_MAX + 1, 9999999);
    digits = $sformatf("%0d", n);
    if ($urandom_range(0, 9) == 0) digits = {"0", digits};
    send_text(digits);
  endtask

  // Mostly well-formed runs and row ends with random counts, now and then a
  // pattern end, with whitespace and arbitrary bytes mixed in as noise.
  task automatic send_random_token();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      send_random_count();
      case ($urandom_range(0, 4))
        0, 1: begin
          send_char(lrle_pkg::CH_DEAD);
        end
        2, 3: begin
          send_char("o");
        end
        default: begin
          send_char(8'($urandom_range(0, 255)));
        end
      endcase
    end else if (pick < 72) begin
      send_random_count();
      send_char(lrle_pkg::CH_ROW_END);
    end else if (pick < 76) begin
      if ($urandom_range(0, 3) == 0) send_random_count();
      send_char(lrle_pkg::CH_PAT_END);
    end else if (pick < 86) begin
      case ($urandom_range(0, 2))
        0: begin
          send_char(lrle_pkg::CH_SPACE);
        end
        1: begin
          send_char(lrle_pkg::CH_TAB);
        end
        default: begin
          send_char(lrle_pkg::CH_NEWLINE);
        end
      endcase
    end else begin
      send_char(8'($urandom_range(0, 255)));
    end
  endtask

  // Several phases, each under a new width, mostly narrow ones so that rows
  // both fall short of and overrun the width. The last phase runs flat out.
  task automatic test_random_patterns();
    int unsigned target;
    int unsigned pick;
    logic [lrle_pkg::WIDTH_W-1:0] w;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) w = lrle_pkg::WIDTH_W'($urandom_range(1, 40));
      else if (pick < 8) w = lrle_pkg::WIDTH_W'($urandom_range(41, 300));
      else if (pick < 9) w = lrle_pkg::WIDTH_W'($urandom_range(301, 4096));
      else w = lrle_pkg::WIDTH_W'($urandom_range(0, 8191));
      set_row_width(w);
      src_gaps = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      sink_stalls = (phase != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      target = chars_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (chars_sent < target) send_random_token();
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    char_bus.valid <= 1'b0;
    char_bus.char_code <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_chars();
    test_row_widths();
    test_saturation();
    test_count_clearing();
    test_random_patterns();

    // Drain everything still owed, then watch a little longer for strays.
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && decoded_items.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
